[rtl/core/circulation_rate_evaluator_defines.svh]
// Assertion macros for the circulation rate evaluator checker
`ifndef CIRCULATION_RATE_EVALUATOR_DEFINES_SVH
`define CIRCULATION_RATE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define CREV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define CREV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define CREV_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/crev_pkg.sv]
// Types, register indexes and saturating Q16.16 arithmetic for the circulation rate evaluator
package crev_pkg;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN  = 32'sh8000_0000;
  localparam q_t Q_ZERO = 32'sh0000_0000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYS_ART_STORAGE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYS_ART_FLOW_TERMS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYS_VEN_STORAGE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYS_CONDUCTANCES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUL_ART_STORAGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUL_ART_FLOW_TERMS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUL_VEN_STORAGE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PUL_CONDUCTANCES   = 3'd7;

  typedef struct packed {
    q_t left_vent_pressure;
    q_t right_vent_pressure;
    q_t sys_art_volume;
    q_t sys_ven_volume;
    q_t pul_art_volume;
    q_t pul_ven_volume;
  } in_t;

  typedef struct packed {
    q_t sys_art_pressure;
    q_t sys_ven_pressure;
    q_t pul_art_pressure;
    q_t pul_ven_pressure;
    q_t left_vent_rate;
    q_t sys_art_rate;
    q_t sys_ven_rate;
    q_t right_vent_rate;
    q_t pul_art_rate;
    q_t pul_ven_rate;
    q_t stroke_diff_rate;
  } out_t;

  // Flow coefficients taken from the configuration registers
  typedef struct packed {
    q_t g_aortic;
    q_t r_sys_art;
    q_t g_sys_per;
    q_t g_sys_ven;
    q_t g_pul_valve;
    q_t r_pul_art;
    q_t g_pul_per;
    q_t g_pul_ven;
  } coef_t;

  // Clamp a 33-bit sum or difference to the Q16.16 range
  function automatic q_t sat33(input logic signed [32:0] v);
    q_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q_MIN : Q_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  // Full product, floor shift by 16, then clamp
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    q_t r;
    p = 64'(a) * 64'(b);
    s = p >>> 16;
    if (&s[63:31] || ~|s[63:31]) begin
      r = s[31:0];
    end else begin
      r = s[63] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

[rtl/core/crev_compliance.sv]
// Compliance pressure of one vessel: excess volume, then elastance product (two stages)
module crev_compliance (
  input  logic        clk,
  input  logic        advance,
  input  crev_pkg::q_t volume,
  input  crev_pkg::q_t unstressed,
  input  crev_pkg::q_t elastance,
  output crev_pkg::q_t pressure
);
  import crev_pkg::*;

  q_t excess;
  q_t press;

  // Stage one: volume above the unstressed volume
  always_ff @(posedge clk) begin
    if (advance) begin
      excess <= qsub(volume, unstressed);
    end
  end

  // Stage two: scale by elastance
  always_ff @(posedge clk) begin
    if (advance) begin
      press <= qmul(excess, elastance);
    end
  end

  assign pressure = press;

endmodule

[rtl/core/crev_flow_net.sv]
// Valve and peripheral flows, resistive drops and volume rates (stages three to six)
module crev_flow_net (
  input  logic          clk,
  input  logic          advance,
  input  crev_pkg::coef_t coef,
  input  crev_pkg::q_t  lv,
  input  crev_pkg::q_t  rv,
  input  crev_pkg::q_t  psa_c,
  input  crev_pkg::q_t  psv,
  input  crev_pkg::q_t  ppa_c,
  input  crev_pkg::q_t  ppv,
  output crev_pkg::out_t result
);
  import crev_pkg::*;

  // Stage three registers: pressure drops, closed valves forced to zero
  q_t drop_sa, drop_sv, drop_pa, drop_pv, drop_sp, drop_pp;
  q_t psa_c3, psv3, ppa_c3, ppv3;
  // Stage four registers: flows
  q_t f_sa, f_sv, f_pa, f_pv, f_sp, f_pp;
  q_t psa_c4, psv4, ppa_c4, ppv4;
  // Stage five registers: resistive drops and rates
  q_t rdrop_sa, rdrop_pa;
  q_t psa_c5, psv5, ppa_c5, ppv5;
  q_t lv_rate, sa_rate, sv_rate, rv_rate, pa_rate, pv_rate, sd_rate;
  // Stage six: output register
  out_t res;

  // Stage three: drops across valves and peripheral beds
  always_ff @(posedge clk) begin
    if (advance) begin
      drop_sa <= (lv >= psa_c) ? qsub(lv, psa_c) : Q_ZERO;
      drop_sv <= (psv >= rv) ? qsub(psv, rv) : Q_ZERO;
      drop_pa <= (rv >= ppa_c) ? qsub(rv, ppa_c) : Q_ZERO;
      drop_pv <= (ppv >= lv) ? qsub(ppv, lv) : Q_ZERO;
      drop_sp <= qsub(psa_c, psv);
      drop_pp <= qsub(ppa_c, ppv);
      psa_c3  <= psa_c;
      psv3    <= psv;
      ppa_c3  <= ppa_c;
      ppv3    <= ppv;
    end
  end

  // Stage four: flows as drop times conductance
  always_ff @(posedge clk) begin
    if (advance) begin
      f_sa   <= qmul(drop_sa, coef.g_aortic);
      f_sv   <= qmul(drop_sv, coef.g_sys_ven);
      f_pa   <= qmul(drop_pa, coef.g_pul_valve);
      f_pv   <= qmul(drop_pv, coef.g_pul_ven);
      f_sp   <= qmul(drop_sp, coef.g_sys_per);
      f_pp   <= qmul(drop_pp, coef.g_pul_per);
      psa_c4 <= psa_c3;
      psv4   <= psv3;
      ppa_c4 <= ppa_c3;
      ppv4   <= ppv3;
    end
  end

  // Stage five: arterial resistive drops and the volume rates
  always_ff @(posedge clk) begin
    if (advance) begin
      rdrop_sa <= qmul(f_sa, coef.r_sys_art);
      rdrop_pa <= qmul(f_pa, coef.r_pul_art);
      lv_rate  <= qsub(f_pv, f_sa);
      sa_rate  <= qsub(f_sa, f_sp);
      sv_rate  <= qsub(f_sp, f_sv);
      rv_rate  <= qsub(f_sv, f_pa);
      pa_rate  <= qsub(f_pa, f_pp);
      pv_rate  <= qsub(f_pp, f_pv);
      sd_rate  <= qsub(f_sa, f_pa);
      psa_c5   <= psa_c4;
      psv5     <= psv4;
      ppa_c5   <= ppa_c4;
      ppv5     <= ppv4;
    end
  end

  // Stage six: arterial pressures and the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      res.sys_art_pressure <= qadd(psa_c5, rdrop_sa);
      res.sys_ven_pressure <= psv5;
      res.pul_art_pressure <= qadd(ppa_c5, rdrop_pa);
      res.pul_ven_pressure <= ppv5;
      res.left_vent_rate   <= lv_rate;
      res.sys_art_rate     <= sa_rate;
      res.sys_ven_rate     <= sv_rate;
      res.right_vent_rate  <= rv_rate;
      res.pul_art_rate     <= pa_rate;
      res.pul_ven_rate     <= pv_rate;
      res.stroke_diff_rate <= sd_rate;
    end
  end

  assign result = res;

endmodule

[rtl/core/circulation_rate_evaluator.sv]
// Throughput: one item per cycle, except while a held output stalls the pipeline.
// Six register stages, each with at most one multiply in series.
// A held output stalls the whole pipeline in place; nothing is dropped or repeated.
// Reset clears all stage valid bits and the eight configuration registers to zero.
module circulation_rate_evaluator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  crev_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output crev_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [crev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crev_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import crev_pkg::*;

  localparam int unsigned STAGES = 6;

  logic [CFG_DATA_W-1:0] sys_art_storage, sys_art_flow_terms, sys_ven_storage;
  logic [CFG_DATA_W-1:0] sys_conductances, pul_art_storage, pul_art_flow_terms;
  logic [CFG_DATA_W-1:0] pul_ven_storage, pul_conductances;

  logic [STAGES-1:0] vld;
  logic              advance;
  q_t                lv1, rv1, lv2, rv2;
  q_t                psa_c, psv, ppa_c, ppv;
  coef_t             coef;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sys_art_storage    <= '0;
      sys_art_flow_terms <= '0;
      sys_ven_storage    <= '0;
      sys_conductances   <= '0;
      pul_art_storage    <= '0;
      pul_art_flow_terms <= '0;
      pul_ven_storage    <= '0;
      pul_conductances   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYS_ART_STORAGE:    sys_art_storage    <= cfg_data;
        REG_SYS_ART_FLOW_TERMS: sys_art_flow_terms <= cfg_data;
        REG_SYS_VEN_STORAGE:    sys_ven_storage    <= cfg_data;
        REG_SYS_CONDUCTANCES:   sys_conductances   <= cfg_data;
        REG_PUL_ART_STORAGE:    pul_art_storage    <= cfg_data;
        REG_PUL_ART_FLOW_TERMS: pul_art_flow_terms <= cfg_data;
        REG_PUL_VEN_STORAGE:    pul_ven_storage    <= cfg_data;
        REG_PUL_CONDUCTANCES:   pul_conductances   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split register halves into flow coefficients
  always_comb begin
    coef.g_aortic    = $signed(sys_art_flow_terms[63:32]);
    coef.r_sys_art   = $signed(sys_art_flow_terms[31:0]);
    coef.g_sys_per   = $signed(sys_conductances[63:32]);
    coef.g_sys_ven   = $signed(sys_conductances[31:0]);
    coef.g_pul_valve = $signed(pul_art_flow_terms[63:32]);
    coef.r_pul_art   = $signed(pul_art_flow_terms[31:0]);
    coef.g_pul_per   = $signed(pul_conductances[63:32]);
    coef.g_pul_ven   = $signed(pul_conductances[31:0]);
  end

  // Advance every stage unless the output holds an untaken result
  assign advance   = !vld[STAGES-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[STAGES-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // Carry ventricular pressures alongside the compliance stages
  always_ff @(posedge clk) begin
    if (advance) begin
      lv1 <= in_data.left_vent_pressure;
      rv1 <= in_data.right_vent_pressure;
      lv2 <= lv1;
      rv2 <= rv1;
    end
  end

  crev_compliance u_sys_art (
    .clk        (clk),
    .advance    (advance),
    .volume     (in_data.sys_art_volume),
    .unstressed ($signed(sys_art_storage[31:0])),
    .elastance  ($signed(sys_art_storage[63:32])),
    .pressure   (psa_c)
  );

  crev_compliance u_sys_ven (
    .clk        (clk),
    .advance    (advance),
    .volume     (in_data.sys_ven_volume),
    .unstressed ($signed(sys_ven_storage[31:0])),
    .elastance  ($signed(sys_ven_storage[63:32])),
    .pressure   (psv)
  );

  crev_compliance u_pul_art (
    .clk        (clk),
    .advance    (advance),
    .volume     (in_data.pul_art_volume),
    .unstressed ($signed(pul_art_storage[31:0])),
    .elastance  ($signed(pul_art_storage[63:32])),
    .pressure   (ppa_c)
  );

  crev_compliance u_pul_ven (
    .clk        (clk),
    .advance    (advance),
    .volume     (in_data.pul_ven_volume),
    .unstressed ($signed(pul_ven_storage[31:0])),
    .elastance  ($signed(pul_ven_storage[63:32])),
    .pressure   (ppv)
  );

  crev_flow_net u_flow_net (
    .clk     (clk),
    .advance (advance),
    .coef    (coef),
    .lv      (lv2),
    .rv      (rv2),
    .psa_c   (psa_c),
    .psv     (psv),
    .ppa_c   (ppa_c),
    .ppv     (ppv),
    .result  (out_data)
  );

endmodule

[rtl/core/crev_checker.sv]
// Port-level checks for the circulation rate evaluator, bound to the top level
`include "circulation_rate_evaluator_defines.svh"

module crev_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input crev_pkg::out_t out_data
);
  import crev_pkg::*;

  // A held result keeps its value until transferred
  `CREV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // An empty output stage never blocks the input
  `CREV_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")

  // A result transfer frees the pipeline for a new input in the same cycle
  `CREV_ASSERT_NOW(a_ready_on_drain, out_valid && out_ready, in_ready, "input blocked while output drains")

  // Reset empties the pipeline
  `CREV_ASSERT_RST(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind circulation_rate_evaluator crev_checker u_crev_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
